// File: hw/rtl/ivm_pkg.sv
// Package with the shared constants, codes and types of the isophote vote map.
`timescale 1ns / 1ps
package ivm_pkg;

    localparam int MAP_ROW_BITS = 8;
    localparam int MAP_COL_BITS = 9;
    localparam int MAP_ADDR_BITS = MAP_ROW_BITS + MAP_COL_BITS;
    localparam int MAP_DEPTH = 1 << MAP_ADDR_BITS;
    localparam int MAP_MAX_WIDTH = 512;
    localparam int MAP_MAX_HEIGHT = 256;
    localparam int DERIV_BITS = 24;
    localparam int CELL_BITS = 32;

    localparam int MAG_BITS = DERIV_BITS;
    localparam int OPA_BITS = 2 * MAG_BITS;
    localparam int OPB_BITS = MAG_BITS + 1;
    localparam int PROD_BITS = OPA_BITS + OPB_BITS;
    localparam int Q3_BITS = PROD_BITS + 2;
    localparam int DEN_BITS = Q3_BITS - 1;
    localparam int QUO_BITS = 13;
    localparam int DSH_BITS = DEN_BITS + QUO_BITS;
    localparam int DISP_BITS = QUO_BITS;
    localparam int POS_BITS = 14;
    localparam int ROOT_BITS = 56;
    localparam int CURV_BITS = ROOT_BITS / 2;

    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 12;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IMG_WIDTH = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_RADIUS = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_RADIUS = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BORDER_MARGIN = 3'd4;

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_VOTE = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Order of the products formed by the shared shift-add multiplier.
    localparam logic [3:0] MUL_FX2 = 4'd0;
    localparam logic [3:0] MUL_FY2 = 4'd1;
    localparam logic [3:0] MUL_FXY = 4'd2;
    localparam logic [3:0] MUL_T1 = 4'd3;
    localparam logic [3:0] MUL_T2 = 4'd4;
    localparam logic [3:0] MUL_T3 = 4'd5;
    localparam logic [3:0] MUL_SXX = 4'd6;
    localparam logic [3:0] MUL_SYY = 4'd7;
    localparam logic [3:0] MUL_SXY = 4'd8;
    localparam logic [3:0] MUL_NX = 4'd9;
    localparam logic [3:0] MUL_NY = 4'd10;
    localparam int MUL_COUNT = 11;

    typedef enum logic [11:0] {
        S_CLEAR = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_MLD   = 12'b0000_0000_0100,
        S_MUL   = 12'b0000_0000_1000,
        S_Q3    = 12'b0000_0001_0000,
        S_DIV   = 12'b0000_0010_0000,
        S_SQ    = 12'b0000_0100_0000,
        S_CHK   = 12'b0000_1000_0000,
        S_SQRT  = 12'b0001_0000_0000,
        S_RD    = 12'b0010_0000_0000,
        S_UPD   = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } state_t;

    typedef logic [PROD_BITS-1:0] prod_t;

    function automatic logic [MAG_BITS-1:0] f_mag(input logic signed [DERIV_BITS-1:0] v);
        f_mag = v[DERIV_BITS-1] ? MAG_BITS'(-v) : MAG_BITS'(v);
    endfunction

endpackage

// File: hw/rtl/ivm_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module ivm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [WIDTH-1:0]     wdata,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: hw/rtl/isophote_center_vote_map.sv
// Top level of the isophote center vote map: request sequencer, arithmetic and map RAM.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+---------------------------------------------
//  in      | input     | in_valid / in_ready  | req_type, row, col, five derivatives
//  out     | output    | out_valid / out_ready| cell_value, voted, target, best cell/score
//  cfg     | input     | cfg_we (no wait)     | cfg_index, cfg_data
//
// One word is processed at a time. A vote that reaches the map runs eleven products
// on one shift-add multiplier (each one load and 25 steps), 13 divider steps,
// 28 square root steps and one read-modify-write of the map RAM. A vote may instead
// end when it is rejected at the Q3 test or at the target and radius test.
// A clear, and the clearing pass after reset, sweep all 131072 map cells at one per cycle.
// Reset is asynchronous and active low; it restores the register defaults and starts the
// clearing pass, during which in_ready stays low. A finished word waits in the output
// register while the next input word is accepted; the block stalls only in its final state.
`timescale 1ns / 1ps
module isophote_center_vote_map (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           req_type,
    input  logic [7:0]                           row,
    input  logic [8:0]                           col,
    input  logic signed [ivm_pkg::DERIV_BITS-1:0] grad_x,
    input  logic signed [ivm_pkg::DERIV_BITS-1:0] grad_y,
    input  logic signed [ivm_pkg::DERIV_BITS-1:0] second_xx,
    input  logic signed [ivm_pkg::DERIV_BITS-1:0] second_yy,
    input  logic signed [ivm_pkg::DERIV_BITS-1:0] second_xy,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [31:0]                          cell_value,
    output logic                                 voted,
    output logic [7:0]                           target_row,
    output logic [8:0]                           target_col,
    output logic [7:0]                           best_row,
    output logic [8:0]                           best_col,
    output logic [31:0]                          best_score,
    input  logic                                 cfg_we,
    input  logic [ivm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [ivm_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int MB = ivm_pkg::MAG_BITS;
    localparam int PB = ivm_pkg::PROD_BITS;
    localparam int AB = ivm_pkg::MAP_ADDR_BITS;
    localparam int CB = ivm_pkg::CELL_BITS;
    localparam int RB = ivm_pkg::ROOT_BITS;
    localparam int QB = ivm_pkg::QUO_BITS;
    localparam int PSB = ivm_pkg::POS_BITS;

    // Configuration registers.
    logic [9:0]  img_width_reg, img_width_next;
    logic [8:0]  img_height_reg, img_height_next;
    logic [11:0] min_radius_reg, min_radius_next;
    logic [11:0] max_radius_reg, max_radius_next;
    logic [5:0]  margin_reg, margin_next;

    // Sequencer and captured request.
    ivm_pkg::state_t state_reg, state_next;
    logic [1:0]  req_reg, req_next;
    logic [7:0]  row_reg, row_next;
    logic [8:0]  col_reg, col_next;
    logic        fx_neg_reg, fx_neg_next;
    logic        fy_neg_reg, fy_neg_next;
    logic        fxx_neg_reg, fxx_neg_next;
    logic        fyy_neg_reg, fyy_neg_next;
    logic        neg3_reg, neg3_next;
    logic [MB-1:0] ax_reg, ax_next;
    logic [MB-1:0] ay_reg, ay_next;
    logic [MB-1:0] axx_reg, axx_next;
    logic [MB-1:0] ayy_reg, ayy_next;
    logic [MB-1:0] axy_reg, axy_next;

    // Shared shift-add multiplier.
    logic [3:0]  mul_idx_reg, mul_idx_next;
    logic [PB-1:0] mul_a_reg, mul_a_next;
    logic [ivm_pkg::OPB_BITS-1:0] mul_b_reg, mul_b_next;
    logic [PB-1:0] mul_p_reg, mul_p_next;
    logic [4:0]  mul_cnt_reg, mul_cnt_next;
    ivm_pkg::prod_t prod_reg [ivm_pkg::MUL_COUNT];
    ivm_pkg::prod_t prod_next [ivm_pkg::MUL_COUNT];
    logic [ivm_pkg::OPA_BITS-1:0] opa;
    logic [ivm_pkg::OPB_BITS-1:0] opb;
    logic [PB-1:0] mul_sum;

    // Denominator, divider and displacement.
    logic [ivm_pkg::OPA_BITS-1:0] q1_reg, q1_next;
    logic [ivm_pkg::DEN_BITS-1:0] den_reg, den_next;
    logic [PB-1:0] num_x_reg, num_x_next;
    logic [PB-1:0] num_y_reg, num_y_next;
    logic [ivm_pkg::DSH_BITS-1:0] den_sh_reg, den_sh_next;
    logic [QB-1:0] quo_x_reg, quo_x_next;
    logic [QB-1:0] quo_y_reg, quo_y_next;
    logic [3:0]  div_cnt_reg, div_cnt_next;
    logic signed [PSB-1:0] tr_reg, tr_next;
    logic signed [PSB-1:0] tc_reg, tc_next;
    logic [24:0] d2_reg, d2_next;
    logic [23:0] min2_reg, min2_next;
    logic [25:0] maxp2_reg, maxp2_next;

    // Square root of the curvedness.
    logic [RB-1:0] root_op_reg, root_op_next;
    logic [RB-1:0] root_res_reg, root_res_next;
    logic [RB-1:0] root_one_reg, root_one_next;
    logic [4:0]  root_cnt_reg, root_cnt_next;

    // Map access and clearing.
    logic [AB-1:0] addr_reg, addr_next;
    logic [AB-1:0] clr_cnt_reg, clr_cnt_next;
    logic        clr_emit_reg, clr_emit_next;
    logic        ram_we;
    logic [AB-1:0] ram_addr;
    logic [CB-1:0] ram_wdata;
    logic [CB-1:0] ram_rdata;

    // Result under construction, best cell and output register.
    logic [CB-1:0] res_cell_reg, res_cell_next;
    logic        res_voted_reg, res_voted_next;
    logic [7:0]  top_row_reg, top_row_next;
    logic [8:0]  top_col_reg, top_col_next;
    logic [CB-1:0] top_score_reg, top_score_next;
    logic        out_valid_reg, out_valid_next;
    logic [CB-1:0] cell_value_reg, cell_value_next;
    logic        voted_reg, voted_next;
    logic [7:0]  target_row_reg, target_row_next;
    logic [8:0]  target_col_reg, target_col_next;
    logic [7:0]  best_row_reg, best_row_next;
    logic [8:0]  best_col_reg, best_col_next;
    logic [CB-1:0] best_score_reg, best_score_next;

    // Combinational helpers.
    logic [9:0]  w_eff;
    logic [8:0]  h_eff;
    logic signed [PSB-1:0] m_s, w_lim, h_lim, row_s, col_s;
    logic signed [ivm_pkg::Q3_BITS-1:0] t1_s, t2_s, t3_s, q3_s;
    logic        src_ok;
    logic        ge_x, ge_y;
    logic [QB-2:0] qx_sat, qy_sat;
    logic signed [QB-1:0] dx_s, dy_s;
    logic [48:0] curv_sum;
    logic [RB-1:0] curv_scaled;
    logic [RB-1:0] root_trial;
    logic [CB:0] cell_sum;
    logic [CB-1:0] cell_new;
    logic        chk_ok;

    ivm_ram #(
        .WIDTH (CB),
        .DEPTH (ivm_pkg::MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Widths and heights above the map size act as the map size.
    assign w_eff = (img_width_reg > 10'(ivm_pkg::MAP_MAX_WIDTH))
                   ? 10'(ivm_pkg::MAP_MAX_WIDTH) : img_width_reg;
    assign h_eff = (img_height_reg > 9'(ivm_pkg::MAP_MAX_HEIGHT))
                   ? 9'(ivm_pkg::MAP_MAX_HEIGHT) : img_height_reg;
    assign m_s   = $signed({8'b0, margin_reg});
    assign w_lim = $signed({4'b0, w_eff}) - m_s;
    assign h_lim = $signed({5'b0, h_eff}) - m_s;
    assign row_s = $signed({6'b0, row_reg});
    assign col_s = $signed({5'b0, col_reg});
    assign src_ok = (row_s >= m_s) && (row_s < h_lim) && (col_s >= m_s) && (col_s < w_lim);

    // Operand selection for the multiplier.
    always_comb
    begin
        opa = '0;
        opb = '0;
        case (mul_idx_reg)
            ivm_pkg::MUL_FX2: begin opa = 48'(ax_reg); opb = 25'(ax_reg); end
            ivm_pkg::MUL_FY2: begin opa = 48'(ay_reg); opb = 25'(ay_reg); end
            ivm_pkg::MUL_FXY: begin opa = 48'(ax_reg); opb = 25'(ay_reg); end
            ivm_pkg::MUL_T1:
            begin
                opa = prod_reg[ivm_pkg::MUL_FY2][47:0];
                opb = 25'(axx_reg);
            end
            ivm_pkg::MUL_T2:
            begin
                opa = prod_reg[ivm_pkg::MUL_FX2][47:0];
                opb = 25'(ayy_reg);
            end
            ivm_pkg::MUL_T3:
            begin
                opa = prod_reg[ivm_pkg::MUL_FXY][47:0];
                opb = {axy_reg, 1'b0};
            end
            ivm_pkg::MUL_SXX: begin opa = 48'(axx_reg); opb = 25'(axx_reg); end
            ivm_pkg::MUL_SYY: begin opa = 48'(ayy_reg); opb = 25'(ayy_reg); end
            ivm_pkg::MUL_SXY: begin opa = 48'(axy_reg); opb = 25'(axy_reg); end
            ivm_pkg::MUL_NX:  begin opa = q1_reg; opb = 25'(ax_reg); end
            ivm_pkg::MUL_NY:  begin opa = q1_reg; opb = 25'(ay_reg); end
            default:          begin opa = '0; opb = '0; end
        endcase
    end

    assign mul_sum = mul_p_reg + (mul_b_reg[0] ? mul_a_reg : '0);

    // Signed terms of Q3 = FY^2*FXX + FX^2*FYY - 2*FX*FXY*FY.
    assign t1_s = fxx_neg_reg ? -$signed({2'b0, prod_reg[ivm_pkg::MUL_T1]})
                              : $signed({2'b0, prod_reg[ivm_pkg::MUL_T1]});
    assign t2_s = fyy_neg_reg ? -$signed({2'b0, prod_reg[ivm_pkg::MUL_T2]})
                              : $signed({2'b0, prod_reg[ivm_pkg::MUL_T2]});
    assign t3_s = neg3_reg ? $signed({2'b0, prod_reg[ivm_pkg::MUL_T3]})
                           : -$signed({2'b0, prod_reg[ivm_pkg::MUL_T3]});
    assign q3_s = t1_s + t2_s + t3_s;

    // One restoring division step for each displacement component.
    assign ge_x = (den_sh_reg <= {{(ivm_pkg::DSH_BITS-PB){1'b0}}, num_x_reg});
    assign ge_y = (den_sh_reg <= {{(ivm_pkg::DSH_BITS-PB){1'b0}}, num_y_reg});

    // A quotient above the displacement limit has its top bit set and saturates.
    assign qx_sat = quo_x_reg[QB-1] ? '1 : quo_x_reg[QB-2:0];
    assign qy_sat = quo_y_reg[QB-1] ? '1 : quo_y_reg[QB-2:0];
    assign dx_s = fx_neg_reg ? -$signed({1'b0, qx_sat}) : $signed({1'b0, qx_sat});
    assign dy_s = fy_neg_reg ? -$signed({1'b0, qy_sat}) : $signed({1'b0, qy_sat});

    // Curvedness before the root: 100 * (FXX^2 + FYY^2 + 2*FXY^2).
    assign curv_sum = 49'(prod_reg[ivm_pkg::MUL_SXX]) + 49'(prod_reg[ivm_pkg::MUL_SYY])
                    + {prod_reg[ivm_pkg::MUL_SXY][47:0], 1'b0};
    assign curv_scaled = {1'b0, curv_sum, 6'b0} + {2'b0, curv_sum, 5'b0}
                       + {5'b0, curv_sum, 2'b0};

    assign root_trial = root_res_reg + root_one_reg;

    // The target must lie strictly inside the margin and the radius within its window.
    assign chk_ok = (d2_reg != '0) && (tc_reg > m_s) && (tr_reg > m_s)
                    && (tc_reg < w_lim) && (tr_reg < h_lim)
                    && (d2_reg >= 25'(min2_reg)) && (26'(d2_reg) < maxp2_reg);

    assign cell_sum = {1'b0, ram_rdata} + (CB+1)'(root_res_reg);
    assign cell_new = cell_sum[CB] ? '1 : cell_sum[CB-1:0];

    always_comb
    begin
        img_width_next  = img_width_reg;
        img_height_next = img_height_reg;
        min_radius_next = min_radius_reg;
        max_radius_next = max_radius_reg;
        margin_next     = margin_reg;
        state_next   = state_reg;
        req_next     = req_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        fx_neg_next  = fx_neg_reg;
        fy_neg_next  = fy_neg_reg;
        fxx_neg_next = fxx_neg_reg;
        fyy_neg_next = fyy_neg_reg;
        neg3_next    = neg3_reg;
        ax_next      = ax_reg;
        ay_next      = ay_reg;
        axx_next     = axx_reg;
        ayy_next     = ayy_reg;
        axy_next     = axy_reg;
        mul_idx_next = mul_idx_reg;
        mul_a_next   = mul_a_reg;
        mul_b_next   = mul_b_reg;
        mul_p_next   = mul_p_reg;
        mul_cnt_next = mul_cnt_reg;
        prod_next    = prod_reg;
        q1_next      = q1_reg;
        den_next     = den_reg;
        num_x_next   = num_x_reg;
        num_y_next   = num_y_reg;
        den_sh_next  = den_sh_reg;
        quo_x_next   = quo_x_reg;
        quo_y_next   = quo_y_reg;
        div_cnt_next = div_cnt_reg;
        tr_next      = tr_reg;
        tc_next      = tc_reg;
        d2_next      = d2_reg;
        min2_next    = min2_reg;
        maxp2_next   = maxp2_reg;
        root_op_next  = root_op_reg;
        root_res_next = root_res_reg;
        root_one_next = root_one_reg;
        root_cnt_next = root_cnt_reg;
        addr_next     = addr_reg;
        clr_cnt_next  = clr_cnt_reg;
        clr_emit_next = clr_emit_reg;
        res_cell_next  = res_cell_reg;
        res_voted_next = res_voted_reg;
        top_row_next   = top_row_reg;
        top_col_next   = top_col_reg;
        top_score_next = top_score_reg;
        out_valid_next  = out_valid_reg;
        cell_value_next = cell_value_reg;
        voted_next      = voted_reg;
        target_row_next = target_row_reg;
        target_col_next = target_col_reg;
        best_row_next   = best_row_reg;
        best_col_next   = best_col_reg;
        best_score_next = best_score_reg;
        in_ready  = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = addr_reg;
        ram_wdata = cell_new;

        if (cfg_we)
        begin
            case (cfg_index)
                ivm_pkg::CFG_IMG_WIDTH:     img_width_next  = cfg_data[9:0];
                ivm_pkg::CFG_IMG_HEIGHT:    img_height_next = cfg_data[8:0];
                ivm_pkg::CFG_MIN_RADIUS:    min_radius_next = cfg_data;
                ivm_pkg::CFG_MAX_RADIUS:    max_radius_next = cfg_data;
                ivm_pkg::CFG_BORDER_MARGIN: margin_next     = cfg_data[5:0];
                default:                    ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ivm_pkg::S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_addr     = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                begin
                    state_next = clr_emit_reg ? ivm_pkg::S_DONE : ivm_pkg::S_IDLE;
                end
            end
            ivm_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    req_next      = req_type;
                    row_next      = row;
                    col_next      = col;
                    fx_neg_next   = grad_x[ivm_pkg::DERIV_BITS-1];
                    fy_neg_next   = grad_y[ivm_pkg::DERIV_BITS-1];
                    fxx_neg_next  = second_xx[ivm_pkg::DERIV_BITS-1];
                    fyy_neg_next  = second_yy[ivm_pkg::DERIV_BITS-1];
                    neg3_next     = grad_x[ivm_pkg::DERIV_BITS-1]
                                  ^ grad_y[ivm_pkg::DERIV_BITS-1]
                                  ^ second_xy[ivm_pkg::DERIV_BITS-1];
                    ax_next       = ivm_pkg::f_mag(grad_x);
                    ay_next       = ivm_pkg::f_mag(grad_y);
                    axx_next      = ivm_pkg::f_mag(second_xx);
                    ayy_next      = ivm_pkg::f_mag(second_yy);
                    axy_next      = ivm_pkg::f_mag(second_xy);
                    res_cell_next  = '0;
                    res_voted_next = 1'b0;
                    case (req_type)
                        ivm_pkg::REQ_CLEAR:
                        begin
                            top_score_next = '0;
                            clr_cnt_next   = '0;
                            clr_emit_next  = 1'b1;
                            state_next     = ivm_pkg::S_CLEAR;
                        end
                        ivm_pkg::REQ_VOTE:
                        begin
                            mul_idx_next = ivm_pkg::MUL_FX2;
                            state_next   = ivm_pkg::S_MLD;
                        end
                        ivm_pkg::REQ_READ:
                        begin
                            addr_next  = {row, col};
                            state_next = ivm_pkg::S_RD;
                        end
                        default: state_next = ivm_pkg::S_DONE;
                    endcase
                end
            end
            ivm_pkg::S_MLD:
            begin
                mul_a_next   = PB'(opa);
                mul_b_next   = opb;
                mul_p_next   = '0;
                mul_cnt_next = '0;
                state_next   = ivm_pkg::S_MUL;
            end
            ivm_pkg::S_MUL:
            begin
                mul_p_next   = mul_sum;
                mul_a_next   = mul_a_reg << 1;
                mul_b_next   = mul_b_reg >> 1;
                mul_cnt_next = mul_cnt_reg + 1'b1;
                if (mul_cnt_reg == 5'(ivm_pkg::OPB_BITS - 1))
                begin
                    prod_next[mul_idx_reg] = mul_sum;
                    mul_idx_next = mul_idx_reg + 1'b1;
                    if (mul_idx_reg == ivm_pkg::MUL_SXY)
                    begin
                        state_next = ivm_pkg::S_Q3;
                    end
                    else if (mul_idx_reg == ivm_pkg::MUL_NY)
                    begin
                        // The first step compares against the denominator times 2^12.
                        num_x_next   = prod_reg[ivm_pkg::MUL_NX];
                        num_y_next   = mul_sum;
                        den_sh_next  = {1'b0, den_reg, {(QB-1){1'b0}}};
                        quo_x_next   = '0;
                        quo_y_next   = '0;
                        div_cnt_next = '0;
                        state_next   = ivm_pkg::S_DIV;
                    end
                    else
                    begin
                        state_next = ivm_pkg::S_MLD;
                    end
                end
            end
            ivm_pkg::S_Q3:
            begin
                q1_next  = prod_reg[ivm_pkg::MUL_FX2][47:0] + prod_reg[ivm_pkg::MUL_FY2][47:0];
                den_next = ivm_pkg::DEN_BITS'(-q3_s);
                // Only a negative Q3 from a source inside the margin can vote.
                if (src_ok && q3_s[ivm_pkg::Q3_BITS-1])
                begin
                    state_next = ivm_pkg::S_MLD;
                end
                else
                begin
                    state_next = ivm_pkg::S_DONE;
                end
            end
            ivm_pkg::S_DIV:
            begin
                if (ge_x)
                begin
                    num_x_next = num_x_reg - den_sh_reg[PB-1:0];
                end
                if (ge_y)
                begin
                    num_y_next = num_y_reg - den_sh_reg[PB-1:0];
                end
                quo_x_next   = {quo_x_reg[QB-2:0], ge_x};
                quo_y_next   = {quo_y_reg[QB-2:0], ge_y};
                den_sh_next  = den_sh_reg >> 1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == 4'(QB - 1))
                begin
                    state_next = ivm_pkg::S_SQ;
                end
            end
            ivm_pkg::S_SQ:
            begin
                tr_next    = row_s + PSB'(dy_s);
                tc_next    = col_s + PSB'(dx_s);
                d2_next    = 25'(qx_sat) * 25'(qx_sat) + 25'(qy_sat) * 25'(qy_sat);
                min2_next  = min_radius_reg * min_radius_reg;
                maxp2_next = ({1'b0, max_radius_reg} + 13'd1) * ({1'b0, max_radius_reg} + 13'd1);
                root_op_next  = curv_scaled;
                root_res_next = '0;
                root_one_next = RB'(1) << (RB - 2);
                root_cnt_next = '0;
                state_next    = ivm_pkg::S_CHK;
            end
            ivm_pkg::S_CHK:
            begin
                addr_next = {tr_reg[7:0], tc_reg[8:0]};
                state_next = chk_ok ? ivm_pkg::S_SQRT : ivm_pkg::S_DONE;
            end
            ivm_pkg::S_SQRT:
            begin
                if (root_op_reg >= root_trial)
                begin
                    root_op_next  = root_op_reg - root_trial;
                    root_res_next = (root_res_reg >> 1) + root_one_reg;
                end
                else
                begin
                    root_res_next = root_res_reg >> 1;
                end
                root_one_next = root_one_reg >> 2;
                root_cnt_next = root_cnt_reg + 1'b1;
                if (root_cnt_reg == 5'(ivm_pkg::CURV_BITS - 1))
                begin
                    state_next = ivm_pkg::S_RD;
                end
            end
            ivm_pkg::S_RD:
            begin
                state_next = ivm_pkg::S_UPD;
            end
            ivm_pkg::S_UPD:
            begin
                if (req_reg == ivm_pkg::REQ_READ)
                begin
                    res_cell_next = ram_rdata;
                end
                else
                begin
                    ram_we = 1'b1;
                    res_voted_next = 1'b1;
                    if (cell_new > top_score_reg)
                    begin
                        top_score_next = cell_new;
                        top_row_next   = addr_reg[AB-1:ivm_pkg::MAP_COL_BITS];
                        top_col_next   = addr_reg[ivm_pkg::MAP_COL_BITS-1:0];
                    end
                end
                state_next = ivm_pkg::S_DONE;
            end
            ivm_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    cell_value_next = res_cell_reg;
                    voted_next      = res_voted_reg;
                    target_row_next = res_voted_reg ? addr_reg[AB-1:ivm_pkg::MAP_COL_BITS] : '0;
                    target_col_next = res_voted_reg ? addr_reg[ivm_pkg::MAP_COL_BITS-1:0] : '0;
                    best_row_next   = top_row_reg;
                    best_col_next   = top_col_reg;
                    best_score_next = top_score_reg;
                    clr_emit_next   = 1'b0;
                    state_next      = ivm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ivm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ivm_pkg::S_CLEAR;
            clr_cnt_reg    <= '0;
            clr_emit_reg   <= 1'b0;
            img_width_reg  <= 10'd320;
            img_height_reg <= 9'd240;
            min_radius_reg <= 12'd2;
            max_radius_reg <= 12'd30;
            margin_reg     <= 6'd10;
            top_row_reg    <= '0;
            top_col_reg    <= '0;
            top_score_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            clr_emit_reg   <= clr_emit_next;
            img_width_reg  <= img_width_next;
            img_height_reg <= img_height_next;
            min_radius_reg <= min_radius_next;
            max_radius_reg <= max_radius_next;
            margin_reg     <= margin_next;
            top_row_reg    <= top_row_next;
            top_col_reg    <= top_col_next;
            top_score_reg  <= top_score_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        fx_neg_reg   <= fx_neg_next;
        fy_neg_reg   <= fy_neg_next;
        fxx_neg_reg  <= fxx_neg_next;
        fyy_neg_reg  <= fyy_neg_next;
        neg3_reg     <= neg3_next;
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        axx_reg      <= axx_next;
        ayy_reg      <= ayy_next;
        axy_reg      <= axy_next;
        mul_idx_reg  <= mul_idx_next;
        mul_a_reg    <= mul_a_next;
        mul_b_reg    <= mul_b_next;
        mul_p_reg    <= mul_p_next;
        mul_cnt_reg  <= mul_cnt_next;
        prod_reg     <= prod_next;
        q1_reg       <= q1_next;
        den_reg      <= den_next;
        num_x_reg    <= num_x_next;
        num_y_reg    <= num_y_next;
        den_sh_reg   <= den_sh_next;
        quo_x_reg    <= quo_x_next;
        quo_y_reg    <= quo_y_next;
        div_cnt_reg  <= div_cnt_next;
        tr_reg       <= tr_next;
        tc_reg       <= tc_next;
        d2_reg       <= d2_next;
        min2_reg     <= min2_next;
        maxp2_reg    <= maxp2_next;
        root_op_reg  <= root_op_next;
        root_res_reg <= root_res_next;
        root_one_reg <= root_one_next;
        root_cnt_reg <= root_cnt_next;
        addr_reg     <= addr_next;
        res_cell_reg <= res_cell_next;
        res_voted_reg <= res_voted_next;
        cell_value_reg <= cell_value_next;
        voted_reg      <= voted_next;
        target_row_reg <= target_row_next;
        target_col_reg <= target_col_next;
        best_row_reg   <= best_row_next;
        best_col_reg   <= best_col_next;
        best_score_reg <= best_score_next;
    end

    assign out_valid  = out_valid_reg;
    assign cell_value = cell_value_reg;
    assign voted      = voted_reg;
    assign target_row = target_row_reg;
    assign target_col = target_col_reg;
    assign best_row   = best_row_reg;
    assign best_col   = best_col_reg;
    assign best_score = best_score_reg;

    // No word is taken while the map is being swept.
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ivm_pkg::S_CLEAR) |-> !in_ready)
        else $error("input accepted during map clear");

    // A vote word never carries cell data.
    a_vote_no_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && voted) |-> (cell_value == '0))
        else $error("vote result carries a cell value");

    // A map update can only raise the best score.
    a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ivm_pkg::S_UPD && req_reg == ivm_pkg::REQ_VOTE)
        |=> (top_score_reg >= $past(top_score_reg)))
        else $error("best score dropped on a vote");

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the isophote center vote map.
`timescale 1ns / 1ps
module testbench;

    // One request word as the sender drives it.
    typedef struct {
        logic [1:0]                            req;
        logic [7:0]                            r;
        logic [8:0]                            c;
        logic signed [ivm_pkg::DERIV_BITS-1:0] gx;
        logic signed [ivm_pkg::DERIV_BITS-1:0] gy;
        logic signed [ivm_pkg::DERIV_BITS-1:0] sxx;
        logic signed [ivm_pkg::DERIV_BITS-1:0] syy;
        logic signed [ivm_pkg::DERIV_BITS-1:0] sxy;
    } request_word_t;

    // One result word as the block returns it.
    typedef struct {
        logic [31:0] cval;
        logic        hit;
        logic [7:0]  trow;
        logic [8:0]  tcol;
        logic [7:0]  brow;
        logic [8:0]  bcol;
        logic [31:0] bscore;
    } result_word_t;

    localparam int CYCLE_LIMIT = 8000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] req_type = ivm_pkg::REQ_CLEAR;
    logic [7:0] row = '0;
    logic [8:0] col = '0;
    logic signed [ivm_pkg::DERIV_BITS-1:0] grad_x = '0;
    logic signed [ivm_pkg::DERIV_BITS-1:0] grad_y = '0;
    logic signed [ivm_pkg::DERIV_BITS-1:0] second_xx = '0;
    logic signed [ivm_pkg::DERIV_BITS-1:0] second_yy = '0;
    logic signed [ivm_pkg::DERIV_BITS-1:0] second_xy = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [31:0] cell_value;
    logic voted;
    logic [7:0] target_row;
    logic [8:0] target_col;
    logic [7:0] best_row;
    logic [8:0] best_col;
    logic [31:0] best_score;
    logic cfg_we = 1'b0;
    logic [ivm_pkg::CFG_IDX_BITS-1:0] cfg_index = ivm_pkg::CFG_IMG_WIDTH;
    logic [ivm_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

    isophote_center_vote_map u_top (.*);

    always #1 clk = ~clk;

    // Requests waiting to be driven, and results the predictor still expects.
    request_word_t pending_requests[$];
    result_word_t  expected_results[$];

    // The predictor's own copy of the map, the best cell and the registers.
    // Cells that were never touched read as zero, which matches the cleared map.
    logic [31:0] vote_cells[int];
    logic [7:0]  lead_row;
    logic [8:0]  lead_col;
    logic [31:0] lead_score;
    int width_reg, height_reg, rmin_reg, rmax_reg, margin_reg;

    // Recently voted cells, so that many reads hit non-zero cells.
    int recent_cells[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit in_fire = 1'b0;
    int error_count = 0;
    int cycle_count = 0;

    // Integer square root, floor, over the full range the votes can reach.
    function automatic logic [63:0] floor_root(input logic [127:0] x);
        logic [127:0] r;
        logic [127:0] c;
        r = '0;
        for (int b = 40; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= x)
                r = c;
        end
        return r[63:0];
    endfunction

    // Displacement component: -f * q1 / q3 with q3 negative, truncated toward zero
    // and saturated to the 13-bit signed range the block uses for targets.
    function automatic int displacement(input logic signed [127:0] f,
                                        input logic signed [127:0] q1,
                                        input logic signed [127:0] den);
        logic signed [127:0] mag;
        logic signed [127:0] q;
        mag = (f < 0) ? -f : f;
        q = (mag * q1) / den;
        if (q > 4095)
            q = 4095;
        return (f < 0) ? -int'(q) : int'(q);
    endfunction

    // Works out the result word of one accepted request and advances the map.
    function automatic result_word_t predict_vote_map(input request_word_t w);
        result_word_t res;
        logic signed [127:0] fx, fy, fxx, fyy, fxy, q1, q3, curv_sum;
        int wd, ht, m, dx, dy, tr, tc, key;
        logic [63:0] magd, curv;
        logic [32:0] total;
        res = '{default: '0};
        if (w.req == ivm_pkg::REQ_CLEAR) begin
            vote_cells.delete();
            lead_score = '0;
        end else if (w.req == ivm_pkg::REQ_READ) begin
            key = {w.r, w.c};
            if (vote_cells.exists(key))
                res.cval = vote_cells[key];
        end else if (w.req == ivm_pkg::REQ_VOTE) begin
            fx = w.gx;
            fy = w.gy;
            fxx = w.sxx;
            fyy = w.syy;
            fxy = w.sxy;
            wd = (width_reg > ivm_pkg::MAP_MAX_WIDTH) ? ivm_pkg::MAP_MAX_WIDTH : width_reg;
            ht = (height_reg > ivm_pkg::MAP_MAX_HEIGHT) ? ivm_pkg::MAP_MAX_HEIGHT : height_reg;
            m = margin_reg;
            q1 = fx * fx + fy * fy;
            q3 = fy * fy * fxx + fx * fx * fyy - 2 * fx * fxy * fy;
            if (int'(w.r) >= m && int'(w.r) < ht - m && int'(w.c) >= m && int'(w.c) < wd - m
                && q3 < 0) begin
                dx = displacement(fx, q1, -q3);
                dy = displacement(fy, q1, -q3);
                tr = int'(w.r) + dy;
                tc = int'(w.c) + dx;
                magd = floor_root(128'(dx * dx + dy * dy));
                if ((dx != 0 || dy != 0) && tc > m && tr > m && tc < wd - m && tr < ht - m
                    && magd >= 64'(rmin_reg) && magd <= 64'(rmax_reg)) begin
                    curv_sum = fxx * fxx + fyy * fyy + 2 * fxy * fxy;
                    curv = floor_root(128'(curv_sum * 100));
                    key = {tr[7:0], tc[8:0]};
                    total = vote_cells.exists(key) ? 33'(vote_cells[key]) : 33'd0;
                    total = total + 33'(curv);
                    // The cell holds at its maximum once the sum no longer fits.
                    if (total > 33'h0_FFFF_FFFF || curv > 64'hFFFF_FFFF)
                        total = 33'h0_FFFF_FFFF;
                    vote_cells[key] = total[31:0];
                    if (total[31:0] > lead_score) begin
                        lead_score = total[31:0];
                        lead_row = tr[7:0];
                        lead_col = tc[8:0];
                    end
                    res.hit = 1'b1;
                    res.trow = tr[7:0];
                    res.tcol = tc[8:0];
                    recent_cells.push_back(key);
                    if (recent_cells.size() > 16)
                        void'(recent_cells.pop_front());
                end
            end
        end
        res.brow = lead_row;
        res.bcol = lead_col;
        res.bscore = lead_score;
        return res;
    endfunction

    // Stimulus builders.
    function automatic request_word_t plain_request(input logic [1:0] req, input int r,
                                                    input int c);
        request_word_t w;
        w = '{default: '0};
        w.req = req;
        w.r = r[7:0];
        w.c = c[8:0];
        return w;
    endfunction

    function automatic request_word_t vote_request(input int r, input int c, input int gx,
                                                   input int gy, input int sxx, input int syy,
                                                   input int sxy);
        request_word_t w;
        w = plain_request(ivm_pkg::REQ_VOTE, r, c);
        w.gx = gx[ivm_pkg::DERIV_BITS-1:0];
        w.gy = gy[ivm_pkg::DERIV_BITS-1:0];
        w.sxx = sxx[ivm_pkg::DERIV_BITS-1:0];
        w.syy = syy[ivm_pkg::DERIV_BITS-1:0];
        w.sxy = sxy[ivm_pkg::DERIV_BITS-1:0];
        return w;
    endfunction

    function automatic int pick_in(input int lo, input int hi);
        if (hi < lo)
            return $urandom_range(0, 255);
        return $urandom_range(lo, hi);
    endfunction

    // A blob-like vote: equal negative second derivatives make the displacement
    // close to the gradient divided by their magnitude, so it lands near a chosen
    // offset. Small disturbances keep the arithmetic honest.
    function automatic request_word_t shaped_vote();
        int s, dx, dy, noise, wd, ht;
        s = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 200000) : $urandom_range(1, 3000);
        dx = int'($urandom_range(0, 80)) - 40;
        dy = int'($urandom_range(0, 80)) - 40;
        noise = s / 4 + 1;
        wd = (width_reg > ivm_pkg::MAP_MAX_WIDTH) ? ivm_pkg::MAP_MAX_WIDTH : width_reg;
        ht = (height_reg > ivm_pkg::MAP_MAX_HEIGHT) ? ivm_pkg::MAP_MAX_HEIGHT : height_reg;
        return vote_request(pick_in(margin_reg, ht - margin_reg - 1),
                            pick_in(margin_reg, wd - margin_reg - 1),
                            dx * s + int'($urandom_range(0, 2 * noise)) - noise,
                            dy * s + int'($urandom_range(0, 2 * noise)) - noise,
                            -s - int'($urandom_range(0, noise)),
                            -s - int'($urandom_range(0, noise)),
                            int'($urandom_range(0, 2 * noise)) - noise);
    endfunction

    function automatic request_word_t noise_request();
        request_word_t w;
        w.req = 2'($urandom_range(0, 3));
        if (w.req == ivm_pkg::REQ_CLEAR)
            w.req = ivm_pkg::REQ_VOTE;
        w.r = 8'($urandom);
        w.c = 9'($urandom);
        w.gx = ivm_pkg::DERIV_BITS'($urandom);
        w.gy = ivm_pkg::DERIV_BITS'($urandom);
        w.sxx = ivm_pkg::DERIV_BITS'($urandom);
        w.syy = ivm_pkg::DERIV_BITS'($urandom);
        w.sxy = ivm_pkg::DERIV_BITS'($urandom);
        return w;
    endfunction

    function automatic void queue_random_phase(input int count, input int clear_at);
        int pick, key;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (i == clear_at)
                pending_requests.push_back(plain_request(ivm_pkg::REQ_CLEAR, 0, 0));
            else if (pick < 72)
                pending_requests.push_back(shaped_vote());
            else if (pick < 80)
                pending_requests.push_back(noise_request());
            else if (pick < 94) begin
                if (recent_cells.size() > 0 && pick < 90) begin
                    key = recent_cells[$urandom_range(0, recent_cells.size() - 1)];
                    pending_requests.push_back(plain_request(ivm_pkg::REQ_READ, key >> 9,
                                                             key & 511));
                end else
                    pending_requests.push_back(plain_request(ivm_pkg::REQ_READ, $urandom,
                                                             $urandom));
            end else
                pending_requests.push_back(plain_request(ivm_pkg::REQ_UNUSED, $urandom,
                                                         $urandom));
        end
    endfunction

    // The caller must write registers only while the block is idle; this task does not
    // enforce it. The predictor takes the new value at once.
    task automatic write_register(input logic [ivm_pkg::CFG_IDX_BITS-1:0] idx,
                                  input int value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[ivm_pkg::CFG_DATA_BITS-1:0];
        case (idx)
            ivm_pkg::CFG_IMG_WIDTH:     width_reg = value & 'h3FF;
            ivm_pkg::CFG_IMG_HEIGHT:    height_reg = value & 'h1FF;
            ivm_pkg::CFG_MIN_RADIUS:    rmin_reg = value & 'hFFF;
            ivm_pkg::CFG_MAX_RADIUS:    rmax_reg = value & 'hFFF;
            ivm_pkg::CFG_BORDER_MARGIN: margin_reg = value & 'h3F;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(input int wd, input int ht, input int rmin, input int rmax,
                             input int m);
        write_register(ivm_pkg::CFG_IMG_WIDTH, wd);
        write_register(ivm_pkg::CFG_IMG_HEIGHT, ht);
        write_register(ivm_pkg::CFG_MIN_RADIUS, rmin);
        write_register(ivm_pkg::CFG_MAX_RADIUS, rmax);
        write_register(ivm_pkg::CFG_BORDER_MARGIN, m);
    endtask

    // Waits until every queued word was taken and every result came back.
    task automatic drain();
        do
            @(posedge clk);
        while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    // Sender: a new word goes out only when the line is free or the last one was taken.
    always @(negedge clk) begin
        if (rst_n) begin
            if (!in_valid || in_fire) begin
                if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    request_word_t w;
                    w = pending_requests.pop_front();
                    req_type <= w.req;
                    row <= w.r;
                    col <= w.c;
                    grad_x <= w.gx;
                    grad_y <= w.gy;
                    second_xx <= w.sxx;
                    second_yy <= w.syy;
                    second_xy <= w.sxy;
                    in_valid <= 1'b1;
                end else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // Monitor: predicts on every accepted request word and checks every result word.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
        in_fire = in_valid && in_ready;
        if (rst_n && in_fire)
            expected_results.push_back(predict_vote_map('{req_type, row, col, grad_x, grad_y,
                                                          second_xx, second_yy, second_xy}));
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result word with no request outstanding");
                error_count++;
            end else begin
                result_word_t e;
                e = expected_results.pop_front();
                check_field("cell_value", e.cval, cell_value);
                check_field("voted", 32'(e.hit), 32'(voted));
                check_field("target_row", 32'(e.trow), 32'(target_row));
                check_field("target_col", 32'(e.tcol), 32'(target_col));
                check_field("best_row", 32'(e.brow), 32'(best_row));
                check_field("best_col", 32'(e.bcol), 32'(best_col));
                check_field("best_score", e.bscore, best_score);
            end
        end
    end

    initial begin
        width_reg = 320;
        height_reg = 240;
        rmin_reg = 2;
        rmax_reg = 30;
        margin_reg = 10;
        lead_row = '0;
        lead_col = '0;
        lead_score = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part with no idling, starting from the reset settings.
        write_all(320, 240, 2, 30, 10);
        pending_requests.push_back(plain_request(ivm_pkg::REQ_CLEAR, 0, 0));
        pending_requests.push_back(plain_request(ivm_pkg::REQ_READ, 0, 0));
        pending_requests.push_back(plain_request(ivm_pkg::REQ_READ, 255, 511));
        // Zero curvature term: no vote.
        pending_requests.push_back(vote_request(100, 100, 0, 0, 0, 0, 0));
        // Positive curvature term: no vote.
        pending_requests.push_back(vote_request(100, 100, 500, 300, 50, 50, 0));
        // A clean vote ten pixels right and five down.
        pending_requests.push_back(vote_request(100, 100, 1000, 500, -100, -100, 0));
        pending_requests.push_back(plain_request(ivm_pkg::REQ_READ, 105, 110));
        // Full-scale derivatives, both signs.
        pending_requests.push_back(vote_request(100, 100, -8388608, -8388608, -8388608,
                                                -8388608, -8388608));
        pending_requests.push_back(vote_request(100, 100, 8388607, 8388607, 8388607,
                                                8388607, 8388607));
        pending_requests.push_back(vote_request(120, 150, 8388607, -8388608, -8388608,
                                                -8388608, 8388607));
        pending_requests.push_back(plain_request(ivm_pkg::REQ_UNUSED, 100, 100));
        // Source on the border, and a target that falls outside.
        pending_requests.push_back(vote_request(9, 100, 1000, 500, -100, -100, 0));
        pending_requests.push_back(vote_request(100, 300, 2000, 0, -100, -100, 0));
        // Zero displacement, then radii below and above the accepted band.
        pending_requests.push_back(vote_request(100, 100, 1, 0, -8000000, -8000000, 0));
        pending_requests.push_back(vote_request(100, 100, 100, 0, -100, -100, 0));
        pending_requests.push_back(vote_request(100, 100, 4000, 0, -100, -100, 0));
        // Mixed derivative steering the curvature term.
        pending_requests.push_back(vote_request(100, 100, 70, 70, -8388607, -8388607, 8388600));
        drain();

        // Smallest image and widest margin: nothing can vote.
        write_all(1, 1, 0, 0, 63);
        pending_requests.push_back(vote_request(0, 0, 1000, 500, -100, -100, 0));
        pending_requests.push_back(plain_request(ivm_pkg::REQ_READ, 105, 110));
        drain();

        // Random phase with no idling, including a run of heavy votes on one cell
        // that drives it into saturation.
        write_all(320, 240, 2, 30, 10);
        for (int i = 0; i < 30; i++)
            pending_requests.push_back(vote_request(100, 100, 70, 70, -8388607, -8388607,
                                                    -8388600));
        pending_requests.push_back(plain_request(ivm_pkg::REQ_READ, 110, 110));
        queue_random_phase(470, -1);
        drain();

        // Largest image, no margin, radius band 0 to 4095; sender mostly idle.
        write_all(512, 256, 0, 4095, 0);
        send_idle_pct = 69;
        recv_stall_pct = 0;
        queue_random_phase(370, 240);
        drain();

        // Small image; receiver mostly stalling.
        write_all(100, 60, 5, 20, 3);
        send_idle_pct = 0;
        recv_stall_pct = 69;
        queue_random_phase(370, -1);
        drain();

        // Both sides idle now and then.
        write_all(200, 150, 1, 50, 20);
        send_idle_pct = 11;
        recv_stall_pct = 11;
        queue_random_phase(370, 300);
        drain();
        repeat (400) @(posedge clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
